// ----- hdl/wvmt_pkg.sv -----
package wvmt_pkg;

  localparam int NUM_ELEMENTS = 32;
  localparam int IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_SCALE  = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;

  localparam logic [1:0] REG_DECAY   = 2'd0;
  localparam logic [1:0] REG_FLOOR   = 2'd1;
  localparam logic [1:0] REG_CEILING = 2'd2;
  localparam logic [1:0] REG_SPREAD  = 2'd3;

  localparam logic [16:0] RATE_RESET = 17'd32768;
  localparam logic [31:0] SPREAD_ONE = 32'd65536;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [33:0] dividend;  // signed
    logic [15:0] divisor;   // unsigned, non-zero
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] quotient;  // signed, truncated toward zero
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7FFFFFFF;
    if (v < -66'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

// ----- hdl/wvmt_ram.sv -----
module wvmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/wvmt_div.sv -----
module wvmt_div (
  input  logic              clk,
  input  logic              rst,
  input  wvmt_pkg::div_req_t req,
  output wvmt_pkg::div_rsp_t rsp
);
  // restoring divider, one quotient bit a cycle
  logic [33:0] quo;
  logic [16:0] part;
  logic [15:0] dvs;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [33:0] qn;

  always_comb begin
    trial = {part[15:0], quo[33]} - {1'b0, dvs};
    qn = {quo[32:0], ~trial[16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd34;
        neg <= req.dividend[33];
        quo <= req.dividend[33] ? (34'd0 - req.dividend) : req.dividend;
        part <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        part <= trial[16] ? {part[15:0], quo[33]} : trial;
        quo <= qn;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quotient <= neg ? (34'd0 - qn) : qn;
        end
      end
    end
  end
endmodule

// ----- hdl/welford_variance_mean_tracker_core.sv -----
// Welford mean/variance tracker. One item is taken at a time: s_tready is
// low while it is worked on. A sample element makes two passes through the
// bit-serial 34-bit divider (mean step, then M2/(n-1)); while n, the vector
// count including the current one, is below two the second pass is skipped.
// Scale and reset commands sweep the variance RAM entry by entry through
// read, wait and write states; an unused command answers with the current
// rate and no RAM access. A result waits in the output register; the next
// item is accepted the cycle after it is taken. Variances live in a RAM
// whose contents after reset are set by a clearing pass over all
// NUM_ELEMENTS entries, during which no item is accepted.
module welford_variance_mean_tracker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // command[1:0], operand_value[33:2], move_toward[34]
  input  logic        s_tlast,   // last_element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // element_index[5:0], target_mean[37:6],
                                 // element_spread[69:38], current_rate[86:70]
  output logic        m_tlast,   // end_flag
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  localparam int IW = wvmt_pkg::IDX_W;
  localparam int N = wvmt_pkg::NUM_ELEMENTS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_D1, S_D1W, S_M2, S_D2W, S_TGT, S_DONE,
    S_SWRD, S_SWWAIT, S_SWWR, S_OUT
  } state_t;
  state_t state;

  logic [16:0] decay, rfloor, rceil;
  logic [30:0] sreset;
  logic [15:0] count;
  logic [16:0] rate;
  logic [IW-1:0] pos;

  logic [1:0]  cmd;
  logic signed [31:0] x;
  logic toward, last;
  logic signed [31:0] oldm, newm, m2, tgt, spr;
  logic [16:0] n;
  logic signed [32:0] d1;
  logic [IW-1:0] sw;

  // RAMs
  logic [IW-1:0] waddr, raddr;
  logic [31:0]   w_mean, w_m2, w_tgt, w_spr;
  logic          we_all, we_spr;
  logic [31:0]   r_mean, r_m2, r_tgt, r_spr;

  wvmt_ram #(.WIDTH(32), .DEPTH(N)) u_mean (.clk, .we(we_all), .waddr, .wdata(w_mean),
    .raddr, .rdata(r_mean));
  wvmt_ram #(.WIDTH(32), .DEPTH(N)) u_m2 (.clk, .we(we_all), .waddr, .wdata(w_m2),
    .raddr, .rdata(r_m2));
  wvmt_ram #(.WIDTH(32), .DEPTH(N)) u_tgt (.clk, .we(we_all), .waddr, .wdata(w_tgt),
    .raddr, .rdata(r_tgt));
  wvmt_ram #(.WIDTH(32), .DEPTH(N)) u_spr (.clk, .we(we_spr), .waddr, .wdata(w_spr),
    .raddr, .rdata(r_spr));

  wvmt_pkg::div_req_t dreq;
  wvmt_pkg::div_rsp_t drsp;
  wvmt_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  logic signed [33:0] diff_t, dd2;
  logic [31:0] m2_upd;

  // magnitude-based truncating Q16.16 product
  function automatic logic signed [65:0] mulq(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic [33:0] ma, mb;
    logic [67:0] p;
    ma = a[33] ? 34'(-a) : 34'(a);
    mb = b[33] ? 34'(-b) : 34'(b);
    p = ma * mb;
    p = p >> 16;
    return (a[33] ^ b[33]) ? -$signed(66'(p)) : $signed(66'(p));
  endfunction

  always_comb begin
    dd2 = 34'(x) - 34'(newm);
    diff_t = 34'(x) - 34'(tgt);
    m2_upd = wvmt_pkg::sat32(66'($signed(m2)) + mulq(34'(d1), dd2));
  end

  logic [16:0] nm1;
  assign nm1 = n - 17'd1;

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = 34'(d1);
    dreq.divisor = n[15:0];
    if (state == S_RD) begin
      dreq.start = 1'b1;
      dreq.dividend = 34'(x) - 34'($signed(r_mean));
    end
    if (state == S_M2 && n > 17'd1) begin
      dreq.start = 1'b1;
      dreq.dividend = 34'($signed(m2_upd));
      dreq.divisor = nm1[15:0];
    end
  end

  assign w_mean = newm;
  assign w_m2 = m2;
  assign w_tgt = tgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      decay <= 17'd62259; rfloor <= 17'd655; rceil <= 17'd32768;
      sreset <= 31'd65536;
      count <= '0; rate <= wvmt_pkg::RATE_RESET; pos <= '0;
      m_tvalid <= 1'b0; we_all <= 1'b0; we_spr <= 1'b0;
      sw <= '0; waddr <= '0; raddr <= '0;
      w_spr <= wvmt_pkg::SPREAD_ONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wvmt_pkg::REG_DECAY:   decay <= cfg_data[16:0];
          wvmt_pkg::REG_FLOOR:   rfloor <= cfg_data[16:0];
          wvmt_pkg::REG_CEILING: rceil <= cfg_data[16:0];
          wvmt_pkg::REG_SPREAD:  sreset <= cfg_data;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      we_all <= 1'b0; we_spr <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          // clear all four RAMs, one entry a cycle
          we_all <= 1'b1; we_spr <= 1'b1;
          waddr <= sw; w_spr <= wvmt_pkg::SPREAD_ONE;
          newm <= '0; m2 <= '0; tgt <= '0;
          sw <= sw + IW'(1);
          if (32'(sw) == N - 1) begin
            sw <= '0; state <= S_IDLE;
          end
        end
        S_IDLE: if (s_tvalid && s_tready) begin
          cmd <= s_tdata[1:0];
          x <= s_tdata[33:2];
          toward <= s_tdata[34];
          last <= s_tlast;
          n <= (count == wvmt_pkg::COUNT_MAX) ? 17'(count) : 17'(count) + 17'd1;
          raddr <= pos; sw <= '0;
          unique case (s_tdata[1:0])
            wvmt_pkg::CMD_SAMPLE: state <= S_D1;
            wvmt_pkg::CMD_SCALE, wvmt_pkg::CMD_RESET: begin
              raddr <= '0; state <= S_SWRD;
            end
            default: begin
              m_tdata <= {1'b0, rate, 70'd0};
              m_tlast <= 1'b0;
              state <= S_OUT;
            end
          endcase
        end
        S_D1: begin
          // hold while the registered read completes
          state <= S_RD;
        end
        S_RD: begin
          oldm <= r_mean; m2 <= r_m2; tgt <= r_tgt; spr <= r_spr;
          d1 <= 33'(x) - 33'($signed(r_mean));
          state <= S_D1W;
        end
        S_D1W: if (drsp.done) begin
          newm <= wvmt_pkg::sat32(66'($signed(oldm)) + 66'($signed(drsp.quotient)));
          state <= S_M2;
        end
        S_M2: begin
          m2 <= m2_upd;
          state <= (n > 17'd1) ? S_D2W : S_TGT;
        end
        S_D2W: if (drsp.done) begin
          spr <= wvmt_pkg::sat32(66'($signed(drsp.quotient)));
          state <= S_TGT;
        end
        S_TGT: begin
          tgt <= toward ? wvmt_pkg::sat32(66'($signed(tgt)) + mulq(diff_t, 34'(rate)))
                        : wvmt_pkg::sat32(66'($signed(tgt)) - mulq(diff_t, 34'(rate)));
          state <= S_DONE;
        end
        S_DONE: begin
          logic [33:0] r;
          r = 34'((35'(rate) * 35'(decay)) >> 16);
          we_all <= 1'b1; we_spr <= 1'b1; waddr <= pos; w_spr <= spr;
          if (last) begin
            if (r > 34'h1FFFF) r = 34'h1FFFF;
            if (r < 34'(rfloor)) r = 34'(rfloor);
            rate <= r[16:0];
            count <= n[15:0];
            pos <= '0;
          end else begin
            pos <= (32'(pos) >= N - 1) ? '0 : pos + IW'(1);
          end
          m_tdata <= {1'b0, (last ? r[16:0] : rate), spr, tgt, 6'(pos)};
          m_tlast <= last;
          state <= S_OUT;
        end
        S_SWRD: begin
          raddr <= sw;
          state <= S_SWWAIT;
        end
        S_SWWAIT: state <= S_SWWR;
        S_SWWR: begin
          we_spr <= 1'b1; waddr <= sw;
          w_spr <= (cmd == wvmt_pkg::CMD_SCALE)
                   ? wvmt_pkg::sat32(mulq(34'($signed(r_spr)), 34'(x)))
                   : {1'b0, sreset};
          if (32'(sw) == N - 1) begin
            logic signed [65:0] rr;
            rr = mulq(34'(rate), 34'(x));
            if (cmd == wvmt_pkg::CMD_SCALE) begin
              if (rr > 66'($signed({1'b0, rceil}))) rr = 66'(rceil);
              if (rr < 66'($signed({1'b0, rfloor}))) rr = 66'(rfloor);
              rate <= rr[16:0];
              m_tdata <= {1'b0, rr[16:0], 70'd0};
            end else begin
              rate <= rceil;
              m_tdata <= {1'b0, rceil, 70'd0};
            end
            m_tlast <= 1'b1;
            state <= S_OUT;
          end else begin
            sw <= sw + IW'(1);
            state <= S_SWRD;
          end
        end
        S_OUT: begin
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import wvmt_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [5:0]  idx;
    logic [31:0] tmean;
    logic [31:0] spread;
    logic [16:0] rate;
    logic        fin;
  } result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] val;
    logic        toward;
    logic        lst;
    logic        typed;
    result_t     res;
  } row_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tlast;
  logic [39:0] s_tdata;
  logic        m_tvalid, m_tready, m_tlast;
  logic [87:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;

  welford_variance_mean_tracker_core u_top (.*);

  // tracker copy of the block
  logic signed [31:0] mean_q [NUM_ELEMENTS];
  logic signed [31:0] devsq_q [NUM_ELEMENTS];
  logic signed [31:0] tgt_q [NUM_ELEMENTS];
  logic signed [31:0] spread_q [NUM_ELEMENTS];
  logic [15:0] count_q;
  logic [16:0] rate_q;
  int          pos_q;
  logic [16:0] decay_r, floor_r, ceil_r;
  logic [30:0] spread_init_r;

  result_t pending_q[$];
  int      errors, n_results, n_samples, n_scales, n_resets;
  longint  cycles = 0;
  bit      gap_on, sink_gap_on, hold_sink;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint sat32v(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // (a*b)/65536, truncated toward zero
  function automatic longint qmul(longint a, longint b);
    logic [127:0] pr;
    logic [63:0]  ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    pr = (ma * mb) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(pr[63:0]) : longint'(pr[63:0]);
  endfunction

  function automatic result_t track(logic [1:0] cmd, logic [31:0] val, logic toward,
                                    logic lst);
    result_t     res;
    longint      x, n, oldm, d1, d2, m2, t, r;
    logic [63:0] ur;
    int          p;
    res = '0;
    x = longint'(signed'(val));
    case (cmd)
      CMD_SAMPLE: begin
        p = pos_q;
        n = longint'(count_q) + 1;
        if (n > 65535) n = 65535;
        oldm = mean_q[p];
        d1 = x - oldm;
        mean_q[p] = sat32v(oldm + d1 / n);
        d2 = x - longint'(mean_q[p]);
        m2 = sat32v(longint'(devsq_q[p]) + qmul(d1, d2));
        devsq_q[p] = m2;
        if (n >= 2) spread_q[p] = sat32v(m2 / (n - 1));
        t = qmul(x - longint'(tgt_q[p]), longint'(rate_q));
        t = toward ? longint'(tgt_q[p]) + t : longint'(tgt_q[p]) - t;
        tgt_q[p] = sat32v(t);
        if (lst) begin
          ur = (64'(rate_q) * 64'(decay_r)) >> 16;
          if (ur > 64'h1FFFF) ur = 64'h1FFFF;
          if (ur < 64'(floor_r)) ur = 64'(floor_r);
          rate_q = ur[16:0];
          count_q = n[15:0];
          pos_q = 0;
        end else begin
          pos_q = (p + 1 >= NUM_ELEMENTS) ? 0 : p + 1;
        end
        res.idx = p[5:0];
        res.tmean = tgt_q[p];
        res.spread = spread_q[p];
        res.fin = lst;
        n_samples++;
      end
      CMD_SCALE: begin
        for (int i = 0; i < NUM_ELEMENTS; i++)
          spread_q[i] = sat32v(qmul(longint'(spread_q[i]), x));
        r = qmul(longint'(rate_q), x);
        if (r > longint'(ceil_r)) r = ceil_r;
        if (r < longint'(floor_r)) r = floor_r;
        rate_q = r[16:0];
        res.fin = 1'b1;
        n_scales++;
      end
      CMD_RESET: begin
        for (int i = 0; i < NUM_ELEMENTS; i++) spread_q[i] = {1'b0, spread_init_r};
        rate_q = ceil_r;
        res.fin = 1'b1;
        n_resets++;
      end
      default: ;
    endcase
    res.rate = rate_q;
    return res;
  endfunction

  task automatic send(logic [1:0] cmd, logic [31:0] val, logic toward, logic lst,
                      bit typed = 0, result_t typed_res = '0);
    int      w;
    result_t res;
    if (gap_on) begin
      w = $urandom_range(0, 17);
      if (w > 0) begin
        s_tvalid <= 1'b0;
        repeat (w) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, toward, val, cmd};
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    res = track(cmd, val, toward, lst);
    pending_q.push_back(typed ? typed_res : res);
  endtask

  // write a register once the block has drained
  task automatic write_reg(logic [1:0] idx, logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DECAY:   decay_r = value[16:0];
      REG_FLOOR:   floor_r = value[16:0];
      REG_CEILING: ceil_r = value[16:0];
      default:     spread_init_r = value;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  task automatic random_phase(int count);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 15))
        0: begin
          send(CMD_SCALE, 32'($urandom_range(0, 3 << 16)) - 32'($urandom_range(0, 1 << 16)),
               $urandom_range(0, 1), $urandom_range(0, 1));
          sent++;
        end
        1: begin
          send(CMD_RESET, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
          sent++;
        end
        2: begin
          // noise: junk commands and unmarked elements
          send($urandom_range(0, 1) ? CMD_NONE : CMD_SAMPLE, $urandom,
               $urandom_range(0, 1), 1'b0);
          sent++;
        end
        default: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : NUM_ELEMENTS;
          for (int i = 0; i < len; i++)
            send(CMD_SAMPLE, pick_value(), $urandom_range(0, 1), i == len - 1);
          sent += len;
        end
      endcase
    end
  endtask

  // result side
  initial begin
    result_t got, want;
    int      w;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 0;
      end else if (sink_gap_on) begin
        w = $urandom_range(0, 17);
        if (w > 0) begin
          m_tready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = '{m_tdata[5:0], m_tdata[37:6], m_tdata[69:38], m_tdata[86:70], m_tlast};
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.idx !== want.idx) begin
          $error("element_index expected %0d got %0d", want.idx, got.idx); errors++;
        end
        if (got.tmean !== want.tmean) begin
          $error("target_mean expected %h got %h", want.tmean, got.tmean); errors++;
        end
        if (got.spread !== want.spread) begin
          $error("element_spread expected %h got %h", want.spread, got.spread); errors++;
        end
        if (got.rate !== want.rate) begin
          $error("current_rate expected %0d got %0d", want.rate, got.rate); errors++;
        end
        if (got.fin !== want.fin) begin
          $error("end_flag expected %0d got %0d", want.fin, got.fin); errors++;
        end
      end
    end
  end

  row_t rows[$];

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < NUM_ELEMENTS; i++) begin
      mean_q[i] = 0; devsq_q[i] = 0; tgt_q[i] = 0; spread_q[i] = 32'sd65536;
    end
    count_q = 0; rate_q = 17'd32768; pos_q = 0;
    decay_r = 17'd62259; floor_r = 17'd655; ceil_r = 17'd32768;
    spread_init_r = 31'd65536;
    gap_on = 1; sink_gap_on = 1;

    // cmd, operand, toward, last, typed, result
    rows = '{
      '{CMD_SAMPLE, 32'h0, 1, 0, 1, '{6'd0, 32'h0, 32'd65536, 17'd32768, 1'b0}},
      '{CMD_NONE,   32'hFFFFFFFF, 1, 1, 1, '{6'd0, 32'h0, 32'h0, 17'd32768, 1'b0}},
      '{CMD_RESET,  32'h0, 0, 0, 1, '{6'd0, 32'h0, 32'h0, 17'd32768, 1'b1}},
      '{CMD_SAMPLE, 32'h7FFFFFFF, 1, 0, 0, '0},
      '{CMD_SAMPLE, 32'h80000000, 0, 0, 0, '0},
      '{CMD_SAMPLE, 32'hFFFFFFFF, 1, 1, 0, '0},
      '{CMD_SAMPLE, 32'h80000000, 0, 0, 0, '0},
      '{CMD_SAMPLE, 32'h7FFFFFFF, 1, 0, 0, '0},
      '{CMD_SAMPLE, 32'h00010000, 0, 0, 0, '0},
      '{CMD_SCALE,  32'h00020000, 1, 0, 0, '0},
      '{CMD_SAMPLE, 32'h55555555, 1, 1, 0, '0},
      '{CMD_SCALE,  32'h7FFFFFFF, 0, 1, 0, '0},
      '{CMD_SCALE,  32'h80000000, 1, 0, 0, '0},
      '{CMD_SCALE,  32'h0, 0, 0, 0, '0},
      '{CMD_RESET,  32'hAAAAAAAA, 1, 1, 0, '0},
      '{CMD_SCALE,  32'h00010000, 0, 0, 0, '0},
      '{CMD_SAMPLE, 32'hAAAAAAAA, 0, 1, 0, '0},
      '{CMD_SAMPLE, 32'h7FFFFFFF, 0, 0, 0, '0},
      '{CMD_NONE,   32'h12345678, 0, 0, 0, '0},
      '{CMD_SAMPLE, 32'h80000000, 1, 1, 0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      send(rows[i].cmd, rows[i].val, rows[i].toward, rows[i].lst, rows[i].typed,
           rows[i].res);
    drain();

    // floor above ceiling, no decay, widest reset variance
    write_reg(REG_DECAY, 31'd0);
    write_reg(REG_FLOOR, 31'd65536);
    write_reg(REG_CEILING, 31'd0);
    write_reg(REG_SPREAD, 31'h7FFFFFFF);
    random_phase(250);
    drain();

    write_reg(REG_DECAY, 31'd65536);
    write_reg(REG_FLOOR, 31'd0);
    write_reg(REG_CEILING, 31'd65536);
    write_reg(REG_SPREAD, 31'd0);
    gap_on = 0; sink_gap_on = 0;
    random_phase(250);
    drain();

    // stall the output for a long stretch while items keep coming
    hold_sink = 1;
    sink_gap_on = 1;
    random_phase(250);
    drain();

    write_reg(REG_DECAY, 31'($urandom_range(0, 65536)));
    write_reg(REG_FLOOR, 31'($urandom_range(0, 4000)));
    write_reg(REG_CEILING, 31'($urandom_range(4000, 65536)));
    write_reg(REG_SPREAD, 31'($urandom));
    gap_on = 1;
    random_phase(250);
    drain();

    write_reg(REG_DECAY, 31'd62259);
    write_reg(REG_FLOOR, 31'd655);
    write_reg(REG_CEILING, 31'd32768);
    write_reg(REG_SPREAD, 31'd65536);
    sink_gap_on = 0;
    random_phase(250);
    sink_gap_on = 1;
    random_phase(250);
    drain();
    repeat (100) @(posedge clk);

    $display("Checked %0d results: %0d sample elements, %0d scale and %0d reset commands,",
             n_results, n_samples, n_scales, n_resets);
    $display("under five register settings including floor above ceiling and zero decay.");
    if (errors == 0 && pending_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/wvmt_pkg.sv
hdl/wvmt_ram.sv
hdl/wvmt_div.sv
hdl/welford_variance_mean_tracker_core.sv
tb/sv/tb.sv
